// ===== rtl/sync_length_checksum_frame_parser_assert.svh =====
// Assertion macros for the checker file (rtl/slcfp_checker.sv).
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH

// Implication checked in the next cycle, ignored while reset is asserted.
`define SLCFP_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slcfp check failed");

// Implication checked in the next cycle, active through reset as well.
`define SLCFP_CHK_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("slcfp reset check failed");

`endif

// ===== rtl/slcfp_pkg.sv =====
package slcfp_pkg;

    localparam int BYTE_W = 8;
    localparam int FLEN_W = 6;
    localparam int POS_W  = 5;
    // Holds a frame length up to the largest supported payload size.
    localparam int LEN_W  = 7;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;

    // Accepted frame handed from the parser to the emitter.
    typedef struct packed {
        logic [BYTE_W-1:0] cmd;
        logic [LEN_W-1:0]  len;
        logic              bank;
    } t_frame_desc;

endpackage

// ===== rtl/slcfp_ram.sv =====
module slcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/slcfp_fifo.sv =====
module slcfp_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  slcfp_pkg::t_frame_desc i_desc,
    input  logic                 i_pop,
    output slcfp_pkg::t_frame_desc o_desc,
    output logic                 o_valid,
    output logic                 o_full
);
    import slcfp_pkg::*;

    // Two entries: one frame draining, one more parked behind it.
    t_frame_desc r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_desc  = r_entry[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

// ===== rtl/slcfp_front.sv =====
module slcfp_front #(
    parameter int MAX_PAYLOAD = 32,
    parameter int ADDR_W      = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [slcfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slcfp_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                               i_accept,
    input  logic [slcfp_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                               o_wr_en,
    output logic [ADDR_W-1:0]                  o_wr_addr,
    output logic [slcfp_pkg::BYTE_W-1:0]       o_wr_data,
    output logic                               o_desc_push,
    output slcfp_pkg::t_frame_desc             o_desc
);
    import slcfp_pkg::*;

    localparam int IDX_W = ADDR_W - 1;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_cmd, n_cmd;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [BYTE_W-1:0]  r_sum, n_sum;
    logic               r_bank, n_bank;
    logic [BYTE_W-1:0]  r_sync_first;
    logic [BYTE_W-1:0]  r_sync_second;
    logic [LEN_W-1:0]   fill_inc;
    logic               push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default:         r_sync_first  <= r_sync_first;
            endcase
        end
    end

    assign fill_inc = r_fill + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_bank  = r_bank;
        push    = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_rx_byte == r_sync_first) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_rx_byte == r_sync_second) begin
                        n_phase = PH_CMD;
                    end else if (i_rx_byte != r_sync_first) begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_fill = '0;
                    if (i_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                        // oversize: drop the frame, byte is not a sync candidate
                        n_phase = PH_SYNC1;
                        n_cmd   = '0;
                        n_len   = '0;
                        n_sum   = '0;
                    end else begin
                        n_sum   = r_sum + i_rx_byte;
                        n_len   = LEN_W'(i_rx_byte);
                        n_phase = (i_rx_byte == '0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_fill = fill_inc;
                    n_sum  = r_sum + i_rx_byte;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_phase = PH_SYNC1;
                    n_cmd   = '0;
                    n_len   = '0;
                    n_fill  = '0;
                    n_sum   = '0;
                    if (i_rx_byte == r_sum) begin
                        push   = 1'b1;
                        n_bank = ~r_bank;
                    end else if (i_rx_byte == r_sync_first) begin
                        // bad checksum that doubles as a new first sync byte
                        n_phase = PH_SYNC2;
                    end
                end
                default: begin
                    n_phase = PH_SYNC1;
                    n_cmd   = '0;
                    n_len   = '0;
                    n_fill  = '0;
                    n_sum   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_cmd   <= '0;
            r_len   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_bank  <= n_bank;
        end
    end

    assign o_wr_en     = i_accept && (r_phase == PH_DATA);
    assign o_wr_addr   = {r_bank, r_fill[IDX_W-1:0]};
    assign o_wr_data   = i_rx_byte;
    assign o_desc_push = push;
    assign o_desc      = '{cmd: r_cmd, len: r_len, bank: r_bank};

endmodule

// ===== rtl/slcfp_back.sv =====
module slcfp_back #(
    parameter int ADDR_W = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  slcfp_pkg::t_frame_desc         i_desc,
    input  logic                           i_desc_valid,
    output logic                           o_desc_pop,
    output logic                           o_rd_en,
    output logic [ADDR_W-1:0]              o_rd_addr,
    input  logic [slcfp_pkg::BYTE_W-1:0]   i_rd_data,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [slcfp_pkg::BYTE_W-1:0]   o_frame_command,
    output logic [slcfp_pkg::FLEN_W-1:0]   o_frame_length,
    output logic [slcfp_pkg::POS_W-1:0]    o_byte_position,
    output logic [slcfp_pkg::BYTE_W-1:0]   o_payload_value,
    output logic                           o_last
);
    import slcfp_pkg::*;

    localparam int IDX_W = ADDR_W - 1;

    typedef enum logic {
        B_IDLE,
        B_LOAD
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [LEN_W-1:0]   r_k, n_k;
    logic [LEN_W-1:0]   k_inc;
    logic               out_free;
    logic               load;
    logic               last_now;
    logic               empty_frame;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_cmd;
    logic [FLEN_W-1:0]  r_flen;
    logic [POS_W-1:0]   r_pos;
    logic [BYTE_W-1:0]  r_val;
    logic               r_last;

    assign k_inc       = r_k + LEN_W'(1);
    assign out_free    = !r_out_valid || i_pop;
    assign empty_frame = (i_desc.len == '0);
    assign last_now    = empty_frame || (k_inc == i_desc.len);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        load       = 1'b0;
        o_desc_pop = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = {i_desc.bank, r_k[IDX_W-1:0]};
        case (r_state)
            B_IDLE: begin
                if (i_desc_valid) begin
                    o_rd_en = !empty_frame;
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                if (out_free) begin
                    load = 1'b1;
                    if (last_now) begin
                        o_desc_pop = 1'b1;
                        n_k        = '0;
                        n_state    = B_IDLE;
                    end else begin
                        // fetch the next byte while this one goes out
                        n_k       = k_inc;
                        o_rd_en   = 1'b1;
                        o_rd_addr = {i_desc.bank, k_inc[IDX_W-1:0]};
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
                n_k     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_cmd  <= i_desc.cmd;
            r_flen <= i_desc.len[FLEN_W-1:0];
            r_pos  <= r_k[POS_W-1:0];
            r_val  <= empty_frame ? '0 : i_rd_data;
            r_last <= last_now;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_frame_command = r_cmd;
    assign o_frame_length  = r_flen;
    assign o_byte_position = r_pos;
    assign o_payload_value = r_val;
    assign o_last          = r_last;

endmodule

// ===== rtl/sync_length_checksum_frame_parser.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// rx in     | push / full               | i_rx_byte
// result    | empty / pop               | o_frame_command, o_frame_length,
//           |                           | o_byte_position, o_payload_value, o_last
// config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Received bytes are taken one per cycle while full is low; the parser never
// stalls on its own. An accepted frame comes out at one result per cycle, limited
// by pop, once its descriptor has passed the frame queue and the payload RAM read.
// full rises while two accepted frames wait to drain (both payload banks busy).
// Synchronous active-low reset; no clearing pass, the payload RAM is never read
// before it is written. Config writes always complete in the cycle they appear.
module sync_length_checksum_frame_parser #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // rx byte request
    input  logic                              push,
    output logic                              full,
    input  logic [slcfp_pkg::BYTE_W-1:0]      i_rx_byte,
    // result request
    output logic                              empty,
    input  logic                              pop,
    output logic [slcfp_pkg::BYTE_W-1:0]      o_frame_command,
    output logic [slcfp_pkg::FLEN_W-1:0]      o_frame_length,
    output logic [slcfp_pkg::POS_W-1:0]       o_byte_position,
    output logic [slcfp_pkg::BYTE_W-1:0]      o_payload_value,
    output logic                              o_last,
    // config write request
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slcfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slcfp_pkg::BYTE_W-1:0]      i_cfg_data
);
    import slcfp_pkg::*;

    // Payload RAM is split into two banks of 2**IDX_W entries each: the parser
    // fills one bank while the emitter drains the other.
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              desc_push;
    logic              desc_pop;
    logic              desc_valid;
    t_frame_desc       desc_in;
    t_frame_desc       desc_head;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    // Front: sync hunt, header capture, checksum, payload write
    slcfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    slcfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Accepted-frame queue; when it is full both banks hold undrained frames
    slcfp_fifo u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_desc  (desc_head),
        .o_valid (desc_valid),
        .o_full  (full)
    );

    // Back: walks the frame's bank and drives the result register
    slcfp_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desc          (desc_head),
        .i_desc_valid    (desc_valid),
        .o_desc_pop      (desc_pop),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length),
        .o_byte_position (o_byte_position),
        .o_payload_value (o_payload_value),
        .o_last          (o_last)
    );

endmodule

// ===== rtl/slcfp_checker.sv =====
`include "sync_length_checksum_frame_parser_assert.svh"

module slcfp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic [slcfp_pkg::BYTE_W-1:0]      o_frame_command,
    input logic [slcfp_pkg::FLEN_W-1:0]      o_frame_length,
    input logic [slcfp_pkg::POS_W-1:0]       o_byte_position,
    input logic [slcfp_pkg::BYTE_W-1:0]      o_payload_value,
    input logic                              o_last
);
    import slcfp_pkg::*;

    // nothing waits and input is open right after reset
    `SLCFP_CHK_RST(a_reset_clean, !i_rst_n, empty && !full)

    // an unpopped result holds
    `SLCFP_CHK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_payload_value) && $stable(o_last) && $stable(o_byte_position))

    // within a frame positions step by one and the command stays
    `SLCFP_CHK_NEXT(a_position_step, !empty && pop && !o_last, empty || (o_byte_position == POS_W'($past(o_byte_position) + 1'b1) && o_frame_command == $past(o_frame_command)))

    // a new frame starts at position zero
    `SLCFP_CHK_NEXT(a_frame_start, !empty && pop && o_last, empty || o_byte_position == '0)

endmodule

bind sync_length_checksum_frame_parser slcfp_checker u_slcfp_checker (.*);
